>>> rtl/core/volume_trilinear_sampler_defines.svh
// Assertion macros shared by the volume sampler RTL.
`ifndef VOLUME_TRILINEAR_SAMPLER_DEFINES_SVH
`define VOLUME_TRILINEAR_SAMPLER_DEFINES_SVH

// Check cons in the same cycle as ante.
`define VTS_CHECK_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define VTS_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/vts_pkg.sv
// Constants, types and the step table of the volume trilinear sampler.
package vts_pkg;

   localparam int MAX_SIDE    = 32;
   localparam int SIDE_BITS   = $clog2(MAX_SIDE);
   localparam int SIZE_BITS   = 6;
   localparam int VOXEL_BITS  = 16;
   localparam int FRAC_BITS   = 8;
   localparam int POS_BITS    = 13;
   localparam int SAMPLE_BITS = 24;
   localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE * MAX_SIDE;
   localparam int ADDR_BITS   = 3 * SIDE_BITS;

   localparam int WEIGHT_BITS = FRAC_BITS + 1;
   localparam int C_BITS      = VOXEL_BITS + FRAC_BITS;
   localparam int P_BITS      = VOXEL_BITS + 2 * FRAC_BITS;
   localparam int OPND_BITS   = P_BITS;
   localparam int ACC_BITS    = SAMPLE_BITS + 2 * FRAC_BITS;
   localparam int STEP_BITS   = 4;
   localparam int CORNERS     = 8;
   localparam int CORNER_BITS = $clog2(CORNERS);

   localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(MAX_SIDE);

   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIZE_Z = 2'd2;

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   // Operand selects of the multiply-accumulate unit.
   localparam logic [1:0] A_VOX = 2'd0;
   localparam logic [1:0] A_ACC = 2'd1;
   localparam logic [1:0] A_C   = 2'd2;
   localparam logic [1:0] A_P   = 2'd3;

   localparam logic [2:0] B_GX = 3'd0;
   localparam logic [2:0] B_FX = 3'd1;
   localparam logic [2:0] B_GY = 3'd2;
   localparam logic [2:0] B_FY = 3'd3;
   localparam logic [2:0] B_GZ = 3'd4;
   localparam logic [2:0] B_FZ = 3'd5;

   typedef struct packed {
      logic [1:0]             a_sel;
      logic [2:0]             b_sel;
      logic                   clear;
      logic                   save_c;
      logic                   save_p;
      logic [CORNER_BITS-1:0] vox_idx;
   } uop_type;

   // One multiply-accumulate per step: x lerps, y lerp, per z slice; then z lerp.
   function automatic uop_type vts_ucode(input logic [STEP_BITS-1:0] step);
      uop_type u;
      u = '{a_sel: A_VOX, b_sel: B_GX, clear: 1'b0, save_c: 1'b0, save_p: 1'b0,
            vox_idx: '0};
      unique case (step)
         4'd0:  begin u.clear = 1'b1; u.vox_idx = 3'd0; end
         4'd1:  begin u.b_sel = B_FX; u.save_c = 1'b1; u.vox_idx = 3'd1; end
         4'd2:  begin u.clear = 1'b1; u.vox_idx = 3'd2; end
         4'd3:  begin u.b_sel = B_FX; u.vox_idx = 3'd3; end
         4'd4:  begin u.a_sel = A_ACC; u.b_sel = B_FY; u.clear = 1'b1; end
         4'd5:  begin u.a_sel = A_C; u.b_sel = B_GY; u.save_p = 1'b1; end
         4'd6:  begin u.clear = 1'b1; u.vox_idx = 3'd4; end
         4'd7:  begin u.b_sel = B_FX; u.save_c = 1'b1; u.vox_idx = 3'd5; end
         4'd8:  begin u.clear = 1'b1; u.vox_idx = 3'd6; end
         4'd9:  begin u.b_sel = B_FX; u.vox_idx = 3'd7; end
         4'd10: begin u.a_sel = A_ACC; u.b_sel = B_FY; u.clear = 1'b1; end
         4'd11: begin u.a_sel = A_C; u.b_sel = B_GY; end
         4'd12: begin u.a_sel = A_ACC; u.b_sel = B_FZ; u.clear = 1'b1; end
         4'd13: begin u.a_sel = A_P; u.b_sel = B_GZ; end
         default: u.clear = 1'b1;
      endcase
      return u;
   endfunction

endpackage

>>> rtl/core/vts_ram.sv
// Generic single-port RAM with registered read data.
module vts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/volume_trilinear_sampler.sv
// Volume trilinear sampler: voxel store, sample sequencer and result register.
//
// Usage: each req_ word is either a voxel write (req_type 0) or a sample
// (req_type 1). A write stores req_voxel_value at the integer part of the
// position; a sample returns the trilinear interpolation of the eight voxels
// around the 5.8 fixed-point position, as 16.8 fixed point, truncated. Every
// req_ word yields exactly one rsp_ word. Sample positions past size minus
// one and write integer parts past it give rsp_out_of_range, store untouched.
// The csr_ channel writes size_x, size_y, size_z (index 0..2); csr_ready is
// always high. Write sizes only while the block is idle.
// Timing: a write or rejected word goes from idle via done to the output
// register; the next word can be accepted once back in idle. The eight
// sample corner reads go one per cycle through the single store port; the
// fourteen lerp steps share one multiply-accumulate unit, overlapping them.
// Reset clears the control state and sets all sizes to 32; store contents are
// undefined until written. When the receiver stalls, the result waits in the
// output register and one further word may be accepted and worked off; the
// block then holds req_ready low until the output register frees.
`include "volume_trilinear_sampler_defines.svh"

module volume_trilinear_sampler
   import vts_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_type,
   input  logic [POS_BITS-1:0]       req_pos_x,
   input  logic [POS_BITS-1:0]       req_pos_y,
   input  logic [POS_BITS-1:0]       req_pos_z,
   input  logic [VOXEL_BITS-1:0]     req_voxel_value,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [SAMPLE_BITS-1:0]    rsp_sample_value,
   output logic                      rsp_out_of_range,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [SIZE_BITS-1:0]      csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_BUSY = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam logic [STEP_BITS-1:0] STEP_LAST     = '1;
   localparam logic [STEP_BITS-1:0] STEP_MAC0     = STEP_BITS'(2);
   localparam logic [STEP_BITS-1:0] STEP_CAP_LAST = STEP_BITS'(CORNERS);
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE  = WEIGHT_BITS'(1) << FRAC_BITS;

   // Size registers
   logic [SIZE_BITS-1:0] size_x_ff, size_y_ff, size_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_RESET;
         size_y_ff <= SIZE_RESET;
         size_z_ff <= SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_SIZE_X) size_x_ff <= csr_wdata;
         if (csr_index == CSR_SIZE_Y) size_y_ff <= csr_wdata;
         if (csr_index == CSR_SIZE_Z) size_z_ff <= csr_wdata;
      end
   end

   assign csr_ready = 1'b1;

   // Oversize registers act as the full side
   logic [SIZE_BITS-1:0] eff_x, eff_y, eff_z;
   assign eff_x = (size_x_ff > SIZE_RESET) ? SIZE_RESET : size_x_ff;
   assign eff_y = (size_y_ff > SIZE_RESET) ? SIZE_RESET : size_y_ff;
   assign eff_z = (size_z_ff > SIZE_RESET) ? SIZE_RESET : size_z_ff;

   // Request decode
   logic [SIDE_BITS-1:0] ix, iy, iz;
   logic [SIDE_BITS-1:0] ix_up, iy_up, iz_up;
   logic [SIZE_BITS-1:0] ix_inc, iy_inc, iz_inc;
   logic                 wr_bad, sm_bad, req_bad, req_accept;

   assign ix = req_pos_x[POS_BITS-1:FRAC_BITS];
   assign iy = req_pos_y[POS_BITS-1:FRAC_BITS];
   assign iz = req_pos_z[POS_BITS-1:FRAC_BITS];

   assign wr_bad = ({1'b0, ix} >= eff_x) || ({1'b0, iy} >= eff_y) || ({1'b0, iz} >= eff_z);

   assign sm_bad = (eff_x == '0) || (eff_y == '0) || (eff_z == '0) ||
                   ({1'b0, req_pos_x} > {eff_x - SIZE_BITS'(1), FRAC_BITS'(0)}) ||
                   ({1'b0, req_pos_y} > {eff_y - SIZE_BITS'(1), FRAC_BITS'(0)}) ||
                   ({1'b0, req_pos_z} > {eff_z - SIZE_BITS'(1), FRAC_BITS'(0)});

   assign req_bad    = (req_type == REQ_SAMPLE) ? sm_bad : wr_bad;
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;

   // Clamp the upper neighbor to the last slice
   assign ix_inc = {1'b0, ix} + SIZE_BITS'(1);
   assign iy_inc = {1'b0, iy} + SIZE_BITS'(1);
   assign iz_inc = {1'b0, iz} + SIZE_BITS'(1);
   assign ix_up  = (ix_inc < eff_x) ? ix_inc[SIDE_BITS-1:0] : ix;
   assign iy_up  = (iy_inc < eff_y) ? iy_inc[SIDE_BITS-1:0] : iy;
   assign iz_up  = (iz_inc < eff_z) ? iz_inc[SIDE_BITS-1:0] : iz;

   // Sequencer state
   logic [1:0]             state_ff, state_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic                   load_item;
   logic [SIDE_BITS-1:0]   x0_ff, x1_ff, y0_ff, y1_ff, z0_ff, z1_ff;
   logic [FRAC_BITS-1:0]   fx_ff, fy_ff, fz_ff;

   always_ff @(posedge clock) begin
      if (load_item) begin
         x0_ff <= ix;
         y0_ff <= iy;
         z0_ff <= iz;
         x1_ff <= ix_up;
         y1_ff <= iy_up;
         z1_ff <= iz_up;
         fx_ff <= req_pos_x[FRAC_BITS-1:0];
         fy_ff <= req_pos_y[FRAC_BITS-1:0];
         fz_ff <= req_pos_z[FRAC_BITS-1:0];
      end
   end

   // Voxel store: writes at acceptance, corner reads while busy
   logic [CORNER_BITS-1:0] corner;
   logic                   ram_we;
   logic [ADDR_BITS-1:0]   ram_addr;
   logic [VOXEL_BITS-1:0]  ram_rdata;

   assign corner = step_ff[CORNER_BITS-1:0];
   assign ram_we = req_accept && (req_type == REQ_WRITE) && !wr_bad;
   assign ram_addr = ram_we ? {iz, iy, ix}
                            : {corner[2] ? z1_ff : z0_ff,
                               corner[1] ? y1_ff : y0_ff,
                               corner[0] ? x1_ff : x0_ff};

   vts_ram #(
      .WIDTH (VOXEL_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_voxel_value),
      .rdata (ram_rdata)
   );

   // Corner buffer: read data lands in the cycle after its address
   logic [VOXEL_BITS-1:0]  vox_ff [CORNERS];
   logic [STEP_BITS-1:0]   step_m1;
   logic                   cap_en;

   assign step_m1 = step_ff - STEP_BITS'(1);
   assign cap_en  = (state_ff == ST_BUSY) && (step_ff != '0) && (step_ff <= STEP_CAP_LAST);

   always_ff @(posedge clock) begin
      if (cap_en) begin
         vox_ff[step_m1[CORNER_BITS-1:0]] <= ram_rdata;
      end
   end

   // Shared multiply-accumulate unit, fed through the store read register and the corner buffer
   uop_type                         uop;
   logic                            mac_en;
   logic [OPND_BITS-1:0]            mac_a;
   logic [WEIGHT_BITS-1:0]          mac_b;
   logic [OPND_BITS+WEIGHT_BITS-1:0] mac_prod;
   logic [ACC_BITS-1:0]             acc_ff, acc_in;
   logic [C_BITS-1:0]               c_ff;
   logic [P_BITS-1:0]               p_ff;

   assign uop    = vts_ucode(step_ff - STEP_MAC0);
   assign mac_en = (state_ff == ST_BUSY) && (step_ff >= STEP_MAC0);

   always_comb begin
      unique case (uop.a_sel)
         A_VOX:   mac_a = OPND_BITS'(vox_ff[uop.vox_idx]);
         A_ACC:   mac_a = acc_ff[OPND_BITS-1:0];
         A_C:     mac_a = OPND_BITS'(c_ff);
         A_P:     mac_a = p_ff;
         default: mac_a = '0;
      endcase
      unique case (uop.b_sel)
         B_GX:    mac_b = WEIGHT_ONE - {1'b0, fx_ff};
         B_FX:    mac_b = {1'b0, fx_ff};
         B_GY:    mac_b = WEIGHT_ONE - {1'b0, fy_ff};
         B_FY:    mac_b = {1'b0, fy_ff};
         B_GZ:    mac_b = WEIGHT_ONE - {1'b0, fz_ff};
         B_FZ:    mac_b = {1'b0, fz_ff};
         default: mac_b = '0;
      endcase
   end

   assign mac_prod = {{WEIGHT_BITS{1'b0}}, mac_a} * {{OPND_BITS{1'b0}}, mac_b};
   assign acc_in   = (uop.clear ? '0 : acc_ff) + mac_prod[ACC_BITS-1:0];

   always_ff @(posedge clock) begin
      if (mac_en) begin
         acc_ff <= acc_in;
         if (uop.save_c) c_ff <= acc_in[C_BITS-1:0];
         if (uop.save_p) p_ff <= acc_in[P_BITS-1:0];
      end
   end

   // Control: idle -> busy (samples) -> done -> idle
   logic [SAMPLE_BITS-1:0] res_ff, res_in;
   logic                   oor_ff, oor_in;
   logic                   out_load;

   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      res_in    = res_ff;
      oor_in    = oor_ff;
      load_item = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if ((req_type == REQ_SAMPLE) && !req_bad) begin
                  state_in  = ST_BUSY;
                  step_in   = '0;
                  load_item = 1'b1;
               end else begin
                  // Writes and rejected words go straight to done
                  state_in = ST_DONE;
                  res_in   = '0;
                  oor_in   = req_bad;
               end
            end
         end
         ST_BUSY: begin
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_LAST) begin
               state_in = ST_DONE;
               res_in   = acc_in[ACC_BITS-1 -: SAMPLE_BITS];
               oor_in   = 1'b0;
            end
         end
         ST_DONE: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      res_ff  <= res_in;
      oor_ff  <= oor_in;
   end

   // Output register: hold while the receiver stalls
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_value_ff;
   logic                   rsp_oor_ff;

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_load) begin
         rsp_value_ff <= res_ff;
         rsp_oor_ff   <= oor_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = rsp_value_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   // Checks
   `VTS_CHECK_NEXT(a_sample_starts, req_accept && (req_type == REQ_SAMPLE) && !sm_bad, (state_ff == ST_BUSY) && (step_ff == '0), "in-range sample did not start the sequencer")
   `VTS_CHECK_NEXT(a_busy_runs, (state_ff == ST_BUSY) && (step_ff != STEP_LAST), state_ff == ST_BUSY, "sequencer left busy before the last step")
   `VTS_CHECK_NOW(a_store_write_idle, ram_we, (state_ff == ST_IDLE) && req_valid, "store written outside an accepted word")
   `VTS_CHECK_NOW(a_reject_zero, rsp_valid && rsp_out_of_range, rsp_sample_value == '0, "rejected word carries a nonzero sample")

endmodule
